// ----- rtl/ufrs_pkg.sv -----
// ----------------------------------------------------------------------------
// ufrs_pkg - shared types and constants for the union-find engine
// Payload structs, controller states and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ufrs_pkg;

    localparam int NODE_W     = 16;
    localparam int CNT_W      = 16;
    localparam int NODE_COUNT = 65536;
    localparam int PTR_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    typedef struct packed {
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } edge_t;

    typedef struct packed {
        logic             merged;
        logic [CNT_W-1:0] tree_edge_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_LOAD_PA,
        ST_LOAD_PB,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RD_NODE_A,
        RD_NODE_B,
        RD_PAR_A,
        RD_PAR_B
    } rd_sel_t;

    typedef struct packed {
        logic    clr_step;
        logic    load_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    ld_pa;
        logic    ld_pb;
        logic    wr_a;
        logic    wr_b;
        logic    set_merged;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic par_eq;
        logic par_lt;
        logic a_root;
        logic b_root;
    } stat_t;

endpackage

// ----- rtl/ufrs_ram.sv -----
// ----------------------------------------------------------------------------
// ufrs_ram - generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ufrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ufrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// ufrs_ctrl - controller for the union-find engine
// Sequences the clearing pass, the parent fetches and the walk/splice loop.
// ----------------------------------------------------------------------------
module ufrs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           edge_valid,
    output logic           edge_ready,
    output logic           result_valid,
    input  logic           result_ready,
    input  ufrs_pkg::stat_t stat,
    output ufrs_pkg::cmd_t  cmd
);
    import ufrs_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_NODE_A;
        edge_ready     = 1'b0;

        if (result_valid && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                edge_ready = 1'b1;
                if (edge_valid)
                begin
                    cmd.load_in = 1'b1;
                    // out-of-range endpoints skip the walk
                    state_next  = stat.in_range ? ST_FETCH_A : ST_FINISH;
                end
            end
            ST_FETCH_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NODE_A;
                state_next = ST_FETCH_B;
            end
            ST_FETCH_B:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NODE_B;
                cmd.ld_pa  = 1'b1;
                state_next = ST_LOAD_PB;
            end
            ST_LOAD_PA:
            begin
                cmd.ld_pa  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_LOAD_PB:
            begin
                cmd.ld_pb  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (stat.par_eq)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.par_lt)
                begin
                    // splice a onto pb and climb to its old parent
                    cmd.wr_a   = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PAR_A;
                    if (stat.a_root)
                    begin
                        cmd.set_merged = 1'b1;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LOAD_PA;
                    end
                end
                else
                begin
                    cmd.wr_b   = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PAR_B;
                    if (stat.b_root)
                    begin
                        cmd.set_merged = 1'b1;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LOAD_PB;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

// ----- rtl/ufrs_dp.sv -----
// ----------------------------------------------------------------------------
// ufrs_dp - datapath for the union-find engine
// Walk pointers, cached parents, merge counter, result register and the
// parent table.
// ----------------------------------------------------------------------------
module ufrs_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ufrs_pkg::edge_t   edge_data,
    output ufrs_pkg::result_t result_data,
    input  ufrs_pkg::cmd_t    cmd,
    output ufrs_pkg::stat_t   stat
);
    import ufrs_pkg::*;

    logic [PTR_W-1:0] clr_reg;
    logic [PTR_W-1:0] a_reg;
    logic [PTR_W-1:0] b_reg;
    logic [PTR_W-1:0] pa_reg;
    logic [PTR_W-1:0] pb_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             merged_reg;
    result_t          out_reg;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] wr_data;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] rd_data;

    assign count_next = count_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            count_reg  <= '0;
            merged_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + PTR_W'(1);
            end
            if (cmd.load_in)
            begin
                merged_reg <= 1'b0;
            end
            else if (cmd.set_merged)
            begin
                merged_reg <= 1'b1;
                count_reg  <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg <= PTR_W'(edge_data.node_a);
            b_reg <= PTR_W'(edge_data.node_b);
        end
        else if (cmd.wr_a)
        begin
            a_reg <= pa_reg;
        end
        else if (cmd.wr_b)
        begin
            b_reg <= pb_reg;
        end
        if (cmd.ld_pa)
        begin
            pa_reg <= rd_data;
        end
        if (cmd.ld_pb)
        begin
            pb_reg <= rd_data;
        end
        if (cmd.out_load)
        begin
            out_reg.merged          <= merged_reg;
            out_reg.tree_edge_count <= count_reg;
        end
    end

    always_comb
    begin
        wr_en = cmd.clr_step | cmd.wr_a | cmd.wr_b;
        if (cmd.clr_step)
        begin
            wr_addr = clr_reg;
            wr_data = clr_reg;
        end
        else if (cmd.wr_a)
        begin
            wr_addr = a_reg;
            wr_data = pb_reg;
        end
        else
        begin
            wr_addr = b_reg;
            wr_data = pa_reg;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NODE_A: rd_addr = a_reg;
            RD_NODE_B: rd_addr = b_reg;
            RD_PAR_A:  rd_addr = pa_reg;
            RD_PAR_B:  rd_addr = pb_reg;
            default:   rd_addr = a_reg;
        endcase
    end

    ufrs_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NODE_COUNT)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        stat.clr_last = (clr_reg == PTR_W'(NODE_COUNT - 1));
        stat.in_range = (32'(edge_data.node_a) < 32'(NODE_COUNT))
                     && (32'(edge_data.node_b) < 32'(NODE_COUNT));
        stat.par_eq   = (pa_reg == pb_reg);
        stat.par_lt   = (pa_reg < pb_reg);
        stat.a_root   = (a_reg == pa_reg);
        stat.b_root   = (b_reg == pb_reg);
    end

    assign result_data = out_reg;

endmodule

// ----- rtl/union_find_rem_splicing.sv -----
// ----------------------------------------------------------------------------
// union_find_rem_splicing - disjoint-set engine, Rem's algorithm with splicing
//
//   channel   direction  payload     handshake
//   edge      in         edge_t      edge_valid / edge_ready
//   result    out        result_t    result_valid / result_ready
//
// After reset the parent table is filled with identity entries, one per
// cycle, across all NODE_COUNT entries; no request is taken until that ends.
// A request runs accept, two parent fetches, a load, the final compare or
// link and the output load; a splice step is a link and a parent load on the
// parent table's single read port. An out-of-range request goes straight to
// the output load. The next request is taken once the result is registered.
// ----------------------------------------------------------------------------
module union_find_rem_splicing (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              edge_valid,
    output logic              edge_ready,
    input  ufrs_pkg::edge_t   edge_data,
    output logic              result_valid,
    input  logic              result_ready,
    output ufrs_pkg::result_t result_data
);
    import ufrs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ufrs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_ready   (edge_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    ufrs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .edge_data   (edge_data),
        .result_data (result_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
